// ----- rtl/page_frame_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define PFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression that must never be true out of reset
`define PFA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, widths and codes shared by the page frame allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    // field widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned PAGE_W     = 20;
    localparam int unsigned WIDE_W     = 21;
    localparam int unsigned FREE_W     = 21;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TOTAL_W    = 22;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // default sizes
    localparam int unsigned DEF_FREE_STACK_DEPTH = 1024;
    localparam int unsigned DEF_MAX_RUN          = 16;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_RETAIN_ANY    = 2'd0,
        OP_RETAIN_CONTIG = 2'd1,
        OP_RELEASE       = 2'd2,
        OP_QUERY         = 2'd3
    } pfa_opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_PAGES   = 2'd1,
        ST_STACK_FULL = 2'd2
    } pfa_status_t;

    typedef enum logic [0:0] {
        REG_START_PAGE = 1'b0,
        REG_TOP_PAGE   = 1'b1
    } pfa_reg_t;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        emit;
        logic        pop;
        logic        bump;
        logic        push;
        pfa_status_t status;
        logic        last;
    } pfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        pfa_opcode_t op;
        logic        slot_free;
        logic        cnt_zero;
        logic        cnt_one;
        logic        retain_short;
        logic        stack_full;
        logic        stack_empty;
    } pfa_sts_t;

    // configuration write toward the datapath
    typedef struct packed {
        logic              wr_start;
        logic [WIDE_W-1:0] start_page;
        logic [WIDE_W-1:0] top_page;
    } pfa_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pfa_if.sv -----
// ----------------------------------------------------------------------------
// pfa_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_req_if;
    logic                            valid;
    logic                            ready;
    logic [pfa_pkg::OP_W-1:0]        opcode;
    logic [pfa_pkg::COUNT_W-1:0]     page_count;
    logic [pfa_pkg::PAGE_W-1:0]      page_in;

    modport source (output valid, output opcode, output page_count, output page_in,
                    input ready);
    modport sink   (input valid, input opcode, input page_count, input page_in,
                    output ready);
endinterface

interface pfa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pfa_pkg::PAGE_W-1:0]      page_out;
    logic [pfa_pkg::STATUS_W-1:0]    status;
    logic [pfa_pkg::FREE_W-1:0]      free_pages;
    logic                            last;

    modport source (output valid, output page_out, output status, output free_pages,
                    output last, input ready);
    modport sink   (input valid, input page_out, input status, input free_pages,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfa_ctrl
// Request sequencer: accepts a request, checks it, then steps out its items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_frame_allocator_defines.svh"

module pfa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pfa_pkg::pfa_sts_t sts,
    output pfa_pkg::pfa_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = pfa_pkg::ST_OK;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.slot_free)
                begin
                    unique case (sts.op)
                        pfa_pkg::OP_RETAIN_ANY, pfa_pkg::OP_RETAIN_CONTIG:
                        begin
                            priority if (sts.cnt_zero)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (sts.retain_short)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.last   = 1'b1;
                                cmd.status = pfa_pkg::ST_NO_PAGES;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        pfa_pkg::OP_RELEASE:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (sts.stack_full)
                            begin
                                cmd.status = pfa_pkg::ST_STACK_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                        pfa_pkg::OP_QUERY:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = sts.cnt_one;
                    // normal mode drains the stack before bumping
                    if ((sts.op == pfa_pkg::OP_RETAIN_ANY) && !sts.stack_empty)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else
                    begin
                        cmd.bump = 1'b1;
                    end
                    if (sts.cnt_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PFA_ASSERT(a_run_has_pages, clk, rst_n, (state_reg == S_RUN) |-> !sts.cnt_zero, "run with no pages left")
    `PFA_ASSERT(a_last_ends_request, clk, rst_n, (cmd.emit && cmd.last) |=> (state_reg == S_IDLE), "last item did not end request")
    `PFA_ASSERT_NEVER(a_one_source, clk, rst_n, cmd.pop && cmd.bump, "pop and bump together")

endmodule

`default_nettype wire

// ----- rtl/pfa_dp.sv -----
// ----------------------------------------------------------------------------
// pfa_dp
// Free stack memory, bump pointer, request and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_frame_allocator_defines.svh"

module pfa_dp #(
    parameter int unsigned FREE_STACK_DEPTH = pfa_pkg::DEF_FREE_STACK_DEPTH,
    parameter int unsigned MAX_RUN          = pfa_pkg::DEF_MAX_RUN
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pfa_pkg::pfa_cfg_t              cfg,
    input  wire logic [pfa_pkg::OP_W-1:0]       in_opcode,
    input  wire logic [pfa_pkg::COUNT_W-1:0]    in_page_count,
    input  wire logic [pfa_pkg::PAGE_W-1:0]     in_page_in,
    input  wire pfa_pkg::pfa_cmd_t              cmd,
    output pfa_pkg::pfa_sts_t                   sts,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pfa_pkg::PAGE_W-1:0]          out_page,
    output logic [pfa_pkg::STATUS_W-1:0]        out_status,
    output logic [pfa_pkg::FREE_W-1:0]          out_free,
    output logic                                out_last
);

    localparam int unsigned FW = $clog2(FREE_STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(FREE_STACK_DEPTH);
    localparam int unsigned CW = $clog2(MAX_RUN + 1);

    localparam int unsigned PW = pfa_pkg::PAGE_W;
    localparam int unsigned WW = pfa_pkg::WIDE_W;
    localparam int unsigned TW = pfa_pkg::TOTAL_W;

    // free stack storage and top-of-stack copy
    logic [PW-1:0] mem [FREE_STACK_DEPTH];
    logic [PW-1:0] tos_reg;

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [WW-1:0] bump_reg;
    logic [WW-1:0] bump_next;

    // request registers
    pfa_pkg::pfa_opcode_t op_reg;
    logic [CW-1:0]        cnt_reg;
    logic [PW-1:0]        pin_reg;
    logic [CW-1:0]        cnt_sat;

    // result register
    logic                          ovalid_reg;
    logic [PW-1:0]                 opage_reg;
    pfa_pkg::pfa_status_t          ostatus_reg;
    logic [pfa_pkg::FREE_W-1:0]    ofree_reg;
    logic                          olast_reg;

    logic [WW-1:0]                 bump_left;
    logic [TW-1:0]                 total_cur;
    logic [TW-1:0]                 total_after;
    logic [TW-1:0]                 avail;
    logic [pfa_pkg::FREE_W-1:0]    free_sat;
    logic [PW-1:0]                 page_sel;
    logic [FW-1:0]                 rd_ptr;
    logic                          slot_free;
    logic                          stack_full;
    logic                          stack_empty;

    // count saturation on entry
    always_comb
    begin
        if (32'(in_page_count) > 32'(MAX_RUN))
        begin
            cnt_sat = CW'(MAX_RUN);
        end
        else
        begin
            cnt_sat = CW'(in_page_count);
        end
    end

    // free count arithmetic
    always_comb
    begin
        bump_left   = (cfg.top_page > bump_reg) ? (cfg.top_page - bump_reg) : '0;
        total_cur   = TW'(bump_left) + TW'(fill_reg);
        avail       = (op_reg == pfa_pkg::OP_RETAIN_ANY) ? total_cur : TW'(bump_left);
        total_after = total_cur;
        if (cmd.push)
        begin
            total_after = total_cur + TW'(1);
        end
        else if (cmd.pop || cmd.bump)
        begin
            total_after = total_cur - TW'(1);
        end
        free_sat = (total_after > TW'(pfa_pkg::FREE_MAX)) ? pfa_pkg::FREE_MAX
                                                          : total_after[pfa_pkg::FREE_W-1:0];
    end

    // status toward the controller
    assign stack_full  = (fill_reg == FW'(FREE_STACK_DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign slot_free   = !ovalid_reg || out_ready;

    always_comb
    begin
        sts              = '0;
        sts.op           = op_reg;
        sts.slot_free    = slot_free;
        sts.cnt_zero     = (cnt_reg == '0);
        sts.cnt_one      = (cnt_reg == CW'(1));
        sts.retain_short = (TW'(cnt_reg) > avail);
        sts.stack_full   = stack_full;
        sts.stack_empty  = stack_empty;
    end

    // stack and bump pointer next values
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.push)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_reg - FW'(1);
        end
        bump_next = bump_reg;
        if (cfg.wr_start)
        begin
            bump_next = cfg.start_page;
        end
        else if (cmd.bump)
        begin
            bump_next = bump_reg + WW'(1);
        end
        rd_ptr = fill_next - FW'(1);
    end

    // page handed out by this step
    always_comb
    begin
        page_sel = '0;
        if (cmd.pop)
        begin
            page_sel = tos_reg;
        end
        else if (cmd.bump)
        begin
            page_sel = bump_reg[PW-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            bump_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            bump_reg <= bump_next;
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // free stack write and registered read of the new top entry
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[fill_reg[AW-1:0]] <= pin_reg;
            tos_reg               <= pin_reg;
        end
        else
        begin
            tos_reg <= mem[rd_ptr[AW-1:0]];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= pfa_pkg::pfa_opcode_t'(in_opcode);
            cnt_reg <= cnt_sat;
            pin_reg <= in_page_in;
        end
        else if (cmd.pop || cmd.bump)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.emit)
        begin
            opage_reg   <= page_sel;
            ostatus_reg <= cmd.status;
            ofree_reg   <= free_sat;
            olast_reg   <= cmd.last;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_page   = opage_reg;
    assign out_status = pfa_pkg::STATUS_W'(ostatus_reg);
    assign out_free   = ofree_reg;
    assign out_last   = olast_reg;

    `PFA_ASSERT(a_push_not_full, clk, rst_n, cmd.push |-> !stack_full, "push onto full stack")
    `PFA_ASSERT(a_pop_not_empty, clk, rst_n, cmd.pop |-> !stack_empty, "pop from empty stack")
    `PFA_ASSERT(a_emit_slot_free, clk, rst_n, cmd.emit |-> slot_free, "result overwrites pending result")

endmodule

`default_nettype wire

// ----- rtl/page_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator
// Page frame allocator top level: APB registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state and checked in the evaluate state,
// which waits for a free output register. A release or a query then gives
// its single result; a retain of N pages (N saturated to MAX_RUN) gives one
// page per cycle after the check while the output register is free. Failed
// and zero-count retains give a single result. The free stack memory has a
// single read port and keeps the top entry in a register so that
// consecutive pops go out back to back. A result waits in an output
// register while the next request is taken. The free stack needs no
// clearing pass after reset. Configuration registers: start_page at byte
// 0 (writing it also reloads the bump pointer), top_page at byte 4.
`default_nettype none

module page_frame_allocator #(
    parameter int unsigned FREE_STACK_DEPTH = pfa_pkg::DEF_FREE_STACK_DEPTH,
    parameter int unsigned MAX_RUN          = pfa_pkg::DEF_MAX_RUN
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pfa_req_if.sink                                req,
    pfa_rsp_if.source                              rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pfa_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pfa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfa_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int unsigned WW = pfa_pkg::WIDE_W;

    logic [WW-1:0]     start_page_reg;
    logic [WW-1:0]     top_page_reg;
    logic              cfg_write;
    pfa_pkg::pfa_reg_t reg_idx;
    pfa_pkg::pfa_cfg_t cfg;
    pfa_pkg::pfa_cmd_t cmd;
    pfa_pkg::pfa_sts_t sts;

    // apb decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = pfa_pkg::pfa_reg_t'(paddr[2]);

    always_comb
    begin
        unique case (reg_idx)
            pfa_pkg::REG_START_PAGE: prdata = pfa_pkg::APB_DATA_W'(start_page_reg);
            pfa_pkg::REG_TOP_PAGE:   prdata = pfa_pkg::APB_DATA_W'(top_page_reg);
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_page_reg <= '0;
            top_page_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                pfa_pkg::REG_START_PAGE: start_page_reg <= pwdata[WW-1:0];
                pfa_pkg::REG_TOP_PAGE:   top_page_reg   <= pwdata[WW-1:0];
            endcase
        end
    end

    always_comb
    begin
        cfg            = '0;
        cfg.wr_start   = cfg_write && (reg_idx == pfa_pkg::REG_START_PAGE);
        cfg.start_page = pwdata[WW-1:0];
        cfg.top_page   = top_page_reg;
    end

    // sequencer
    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pfa_dp #(
        .FREE_STACK_DEPTH (FREE_STACK_DEPTH),
        .MAX_RUN          (MAX_RUN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_opcode     (req.opcode),
        .in_page_count (req.page_count),
        .in_page_in    (req.page_in),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_page      (rsp.page_out),
        .out_status    (rsp.status),
        .out_free      (rsp.free_pages),
        .out_last      (rsp.last)
    );

endmodule

`default_nettype wire
